/* src/lbs_pkg.sv */
// ============================================================================
// lbs_pkg: shared types and constants for the skinning block
// Opcodes, matrix layout, arithmetic widths and the control word that travels
// beside the datapath.
// ============================================================================
package lbs_pkg;

    localparam int DEF_MAX_BONES  = 256;
    localparam int DEF_INFLUENCES = 4;

    localparam int WORD_W    = 32;
    localparam int MAT_WORDS = 12;
    localparam int ROWS      = 3;
    localparam int FIELD_LANES = 4;     // influences carried by one request

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_DIR   = 2'd2;

    // weight (unsigned 16) times saturated row (signed 32)
    localparam int WPROD_W = 49;
    // sum over up to four lanes
    localparam int ACC_W   = 52;

    localparam logic [15:0] UNORM_MAX = 16'hFFFF;

    typedef logic [ROWS-1:0][WORD_W-1:0] vec_t;

    typedef struct packed {
        logic valid;
        logic pass;     // result is the input vector
        logic bad;
        vec_t vec;
    } ctl_t;

endpackage

/* src/lbs_lane.sv */
// ============================================================================
// lbs_lane: one influence lane
// Private copy of the bone palette (one matrix per address), the 3x3 plus
// translation transform with Q16.16 rounding, and the weight product.
// ============================================================================
module lbs_lane #(
    parameter int MAX_BONES = lbs_pkg::DEF_MAX_BONES,
    parameter int ADDR_W    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic                                   wr_en,
    input  logic [ADDR_W-1:0]                      wr_bone,
    input  logic [3:0]                             wr_slot,
    input  logic [lbs_pkg::WORD_W-1:0]             wr_value,
    input  logic [ADDR_W-1:0]                      rd_joint,
    input  lbs_pkg::vec_t                          vec,
    input  logic                                   point,
    input  logic [15:0]                            weight,
    output logic [lbs_pkg::ROWS-1:0][lbs_pkg::WPROD_W-1:0] wprod
);
    import lbs_pkg::*;

    logic [MAT_WORDS*WORD_W-1:0] mem [MAX_BONES];

    // stage 1: matrix row read
    logic [MAT_WORDS*WORD_W-1:0] mat_reg;
    vec_t                        vec1_reg;
    logic                        point1_reg;
    logic [15:0]                 w1_reg;

    // stage 2: products
    logic signed [2*WORD_W-1:0]  prod_reg [ROWS][3];
    logic signed [WORD_W-1:0]    tr_reg [ROWS];
    logic                        point2_reg;
    logic [15:0]                 w2_reg;

    // stage 3: rounded rows
    logic signed [WORD_W-1:0]    row_reg [ROWS];
    logic [15:0]                 w3_reg;

    logic signed [WORD_W-1:0]    row_next [ROWS];
    logic [ROWS-1:0][WPROD_W-1:0] wprod_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_bone][wr_slot*WORD_W +: WORD_W] <= wr_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mat_reg    <= mem[rd_joint];
            vec1_reg   <= vec;
            point1_reg <= point;
            w1_reg     <= weight;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int k = 0; k < 3; k++) begin
                    prod_reg[r][k] <=
                        (2*WORD_W)'($signed(mat_reg[(r*4+k)*WORD_W +: WORD_W])) *
                        (2*WORD_W)'($signed(vec1_reg[k]));
                end
                tr_reg[r] <= $signed(mat_reg[(r*4+3)*WORD_W +: WORD_W]);
            end
            point2_reg <= point1_reg;
            w2_reg     <= w1_reg;
        end
    end

    // floor((sum + 2^15) / 2^16), then saturate
    always_comb begin
        logic signed [2*WORD_W+1:0] sum;
        logic signed [2*WORD_W-15:0] q;
        for (int r = 0; r < ROWS; r++) begin
            sum = (2*WORD_W+2)'(prod_reg[r][0]) + (2*WORD_W+2)'(prod_reg[r][1])
                + (2*WORD_W+2)'(prod_reg[r][2]) + (2*WORD_W+2)'(32768);
            if (point2_reg) begin
                sum = sum + ((2*WORD_W+2)'(tr_reg[r]) <<< 16);
            end
            q = (2*WORD_W-14)'(sum >>> 16);
            if (q > (2*WORD_W-14)'(32'sh7FFFFFFF)) begin
                row_next[r] = 32'sh7FFFFFFF;
            end else if (q < -(2*WORD_W-14)'(33'sh080000000)) begin
                row_next[r] = 32'sh80000000;
            end else begin
                row_next[r] = q[WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < ROWS; r++) begin
                row_reg[r] <= row_next[r];
            end
            w3_reg <= w2_reg;
        end
    end

    // zero weight forces zero so an unread palette row never leaks through
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < ROWS; r++) begin
                if (w3_reg == 16'd0) begin
                    wprod_reg[r] <= '0;
                end else begin
                    wprod_reg[r] <= $signed(WPROD_W'(w3_reg)) * WPROD_W'(row_reg[r]);
                end
            end
        end
    end

    assign wprod = wprod_reg;

endmodule

/* src/lbs_merge.sv */
// ============================================================================
// lbs_merge: lane merge and normalization
// Sums the weighted lanes, divides by 65535 with rounding through a folding
// remainder, saturates and holds the output register.
// ============================================================================
module lbs_merge #(
    parameter int LANES = lbs_pkg::FIELD_LANES
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                en,
    input  lbs_pkg::ctl_t                                       ctl_in,
    input  logic [LANES-1:0][lbs_pkg::ROWS-1:0][lbs_pkg::WPROD_W-1:0] wprod,
    output logic                                                out_valid,
    output lbs_pkg::vec_t                                       out_vec,
    output logic                                                out_bad
);
    import lbs_pkg::*;

    ctl_t ctl5_reg, ctl6_reg, ctl7_reg;
    logic signed [ACC_W-1:0] acc_reg [ROWS];
    logic [ACC_W-1:0]        mag_reg [ROWS];
    logic                    neg6_reg [ROWS];
    logic [36:0]             q12_reg [ROWS];
    logic [21:0]             r2_reg [ROWS];
    logic                    neg7_reg [ROWS];

    logic                    valid_reg;
    vec_t                    vec_reg;
    logic                    bad_reg;
    vec_t                    vec_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl5_reg.valid <= 1'b0;
            ctl6_reg.valid <= 1'b0;
            ctl7_reg.valid <= 1'b0;
            valid_reg      <= 1'b0;
        end else if (en) begin
            ctl5_reg  <= ctl_in;
            ctl6_reg  <= ctl5_reg;
            ctl7_reg  <= ctl6_reg;
            valid_reg <= ctl7_reg.valid;
            bad_reg   <= ctl7_reg.bad;
            vec_reg   <= vec_next;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [ACC_W-1:0] s;
        logic [ACC_W-1:0]        m;
        logic [35:0]             q1;
        logic [36:0]             r1;
        logic [20:0]             q2;
        if (en) begin
            for (int r = 0; r < ROWS; r++) begin
                // lane sum
                s = '0;
                for (int l = 0; l < LANES; l++) begin
                    s = s + ACC_W'($signed(wprod[l][r]));
                end
                acc_reg[r] <= s;

                // rounded magnitude
                m = acc_reg[r][ACC_W-1] ? ACC_W'(-acc_reg[r]) : ACC_W'(acc_reg[r]);
                mag_reg[r]  <= m + ACC_W'(UNORM_MAX >> 1);
                neg6_reg[r] <= acc_reg[r][ACC_W-1];

                // x = q*65535 + r folded twice: x>>16 plus the low half
                q1 = mag_reg[r][ACC_W-1:16];
                r1 = 37'(mag_reg[r][15:0]) + 37'(q1);
                q2 = r1[36:16];
                q12_reg[r]  <= 37'(q1) + 37'(q2);
                r2_reg[r]   <= 22'(r1[15:0]) + 22'(q2);
                neg7_reg[r] <= neg6_reg[r];
            end
        end
    end

    always_comb begin
        logic [5:0]         q3;
        logic [16:0]        r3;
        logic [37:0]        q;
        logic signed [38:0] v;
        for (int r = 0; r < ROWS; r++) begin
            q3 = r2_reg[r][21:16];
            r3 = 17'(r2_reg[r][15:0]) + 17'(q3);
            q  = 38'(q12_reg[r]) + 38'(q3) + 38'(r3 >= 17'(UNORM_MAX));
            v  = neg7_reg[r] ? -$signed({1'b0, q}) : $signed({1'b0, q});
            if (ctl7_reg.pass) begin
                vec_next[r] = ctl7_reg.vec[r];
            end else if (v > 39'sh007FFFFFFF) begin
                vec_next[r] = 32'h7FFFFFFF;
            end else if (v < -39'sh0080000000) begin
                vec_next[r] = 32'h80000000;
            end else begin
                vec_next[r] = v[WORD_W-1:0];
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_bad   = bad_reg;

endmodule

/* src/linear_blend_skinning.sv */
// ============================================================================
// linear_blend_skinning: four-influence vertex skinning in Q16.16
// Palette load and point/direction skinning on a streaming interface.
// ============================================================================
// One request enters per cycle, held back only when the result register is full
// and not taken; its result passes the lane stages and the merge registers on
// its way to the output. Each influence has its own lane with a private copy of
// the palette (one 3x4 matrix per address), so all four matrices are read
// in the accept cycle; load requests write every copy and produce no result.
// The four lanes feed a merge stage that sums, divides by 65535 and saturates.
// No clearing pass: palette entries are undefined until loaded.
module linear_blend_skinning #(
    parameter int MAX_BONES  = lbs_pkg::DEF_MAX_BONES,
    parameter int INFLUENCES = lbs_pkg::DEF_INFLUENCES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [8:0]   cfg_wr_data,    // bone_count
    input  logic         s_tvalid,
    output logic         s_tready,
    // vec_x, vec_y, vec_z, joint_ids, joint_weights, load_bone, load_slot,
    // load_value, zero pad
    input  logic [271:0] s_tdata,
    input  logic [1:0]   s_tuser,        // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,        // res_x, res_y, res_z
    output logic         m_tuser         // bad_joint
);
    import lbs_pkg::*;

    localparam int ADDR_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int LANES  = (INFLUENCES < FIELD_LANES) ? INFLUENCES : FIELD_LANES;
    localparam int LANE_DEPTH = 4;

    logic [8:0]  bone_count_reg;
    logic        en;
    logic        accept;
    logic        load_we;
    logic [16:0] bone_ext;
    vec_t        vec_in;
    logic [63:0] joint_ids;
    logic [63:0] joint_weights;
    logic [3:0]  load_slot;
    logic        any_w;
    logic        any_bad;
    ctl_t        ctl_next;
    ctl_t        ctl_reg [LANE_DEPTH];
    logic        m_valid;
    vec_t        m_vec;
    logic        m_bad;
    logic [LANES-1:0][ROWS-1:0][WPROD_W-1:0] wprod;

    assign en       = !m_valid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    assign vec_in        = s_tdata[95:0];
    assign joint_ids     = s_tdata[159:96];
    assign joint_weights = s_tdata[223:160];
    assign bone_ext      = {9'd0, s_tdata[231:224]};
    assign load_slot     = s_tdata[235:232];

    assign load_we = accept && (s_tuser == OP_LOAD) &&
                     (load_slot < 4'(MAT_WORDS)) && (bone_ext < 17'(MAX_BONES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bone_count_reg <= '0;
        end else if (cfg_wr_en) begin
            bone_count_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        logic [15:0] j;
        logic [15:0] w;
        any_w   = 1'b0;
        any_bad = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            j = joint_ids[i*16 +: 16];
            w = joint_weights[i*16 +: 16];
            if (w != 16'd0) begin
                any_w = 1'b1;
                if ((j >= {7'd0, bone_count_reg}) || ({1'b0, j} >= 17'(MAX_BONES))) begin
                    any_bad = 1'b1;
                end
            end
        end
        ctl_next.valid = accept && ((s_tuser == OP_POINT) || (s_tuser == OP_DIR));
        ctl_next.pass  = !any_w || any_bad;
        ctl_next.bad   = any_bad;
        ctl_next.vec   = vec_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < LANE_DEPTH; s++) begin
                ctl_reg[s].valid <= 1'b0;
            end
        end else if (en) begin
            ctl_reg[0] <= ctl_next;
            for (int s = 1; s < LANE_DEPTH; s++) begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        lbs_lane #(
            .MAX_BONES (MAX_BONES),
            .ADDR_W    (ADDR_W)
        ) u_lane (
            .aclk     (aclk),
            .en       (en),
            .wr_en    (load_we),
            .wr_bone  (bone_ext[ADDR_W-1:0]),
            .wr_slot  (load_slot),
            .wr_value (s_tdata[267:236]),
            .rd_joint (joint_ids[g*16 +: ADDR_W]),
            .vec      (vec_in),
            .point    (s_tuser == OP_POINT),
            .weight   (joint_weights[g*16 +: 16]),
            .wprod    (wprod[g])
        );
    end

    lbs_merge #(
        .LANES (LANES)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .ctl_in    (ctl_reg[LANE_DEPTH-1]),
        .wprod     (wprod),
        .out_valid (m_valid),
        .out_vec   (m_vec),
        .out_bad   (m_bad)
    );

    assign m_tvalid = m_valid;
    assign m_tdata  = m_vec;
    assign m_tuser  = m_bad;

endmodule
